/* rtl/pcrb_pkg.sv */
// Shared definitions for the point cloud to range bins block.
// Holds item kinds, register indexes, default sizes and the CORDIC angle table.
// No dependencies.
package pcrb_pkg;

    localparam int DEF_MAX_BINS   = 1024;
    localparam int DEF_COORD_BITS = 20;
    localparam int DEF_ANGLE_BITS = 16;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 20;
    localparam int RANGE_W      = 19;
    localparam int DIST_W       = 20;
    localparam int CNT_W        = 13;
    localparam int CFG_DATA_W   = 48;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CFG_ROT_X      = 3'd0,
        CFG_ROT_Y      = 3'd1,
        CFG_ROT_Z      = 3'd2,
        CFG_HEIGHT_OFS = 3'd3,
        CFG_MIN_HEIGHT = 3'd4,
        CFG_MAX_HEIGHT = 3'd5,
        CFG_MAX_RANGE  = 3'd6,
        CFG_BIN_COUNT  = 3'd7
    } cfg_index_t;

    // atan(2^-i) as a 32-bit fraction of a full turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* rtl/point_cloud_to_range_bins.sv */
// Top level of the point cloud to range bins block.
// Depends on pcrb_pkg and pcrb_ram.
//
// Usage. Items arrive on the s_ channel (valid/ready). A point item is rotated
// by the mount matrix, filtered by height and range, and its planar range is
// min-merged into the bin of its bearing; it gives no result. A read item
// returns one bin on the m_ channel (range_mm, index_valid). A clear item
// empties every bin. Registers are written through the cfg_ channel, which is
// always ready; write them only while the block is idle.
// Sequence. The block takes one item at a time and drops s_ready while busy.
// A point runs rotation on the shared multiplier, a check state, squaring,
// 24 CORDIC steps (the integer square root runs beside them), bin scaling and
// a bin update read and write. A dropped point ends early. A read item reads
// its bin and then waits in S_READ_OUT on any output stall. A clear item, and
// reset, sweep all MAX_BINS entries of the bin memory one entry a cycle, during
// which no item is accepted.
// Stall. A read result waits in the output register until m_ready; a new item
// may be accepted meanwhile, and a second read then holds until it frees.
module point_cloud_to_range_bins
    import pcrb_pkg::*;
#(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic signed [COORD_BITS-1:0] s_x_mm,
    input  logic signed [COORD_BITS-1:0] s_y_mm,
    input  logic signed [COORD_BITS-1:0] s_z_mm,
    input  logic                         s_finite,
    input  logic [9:0]                   s_bin_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [RANGE_W-1:0]           m_range_mm,
    output logic                         m_index_valid,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int AW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int MA    = ((COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS) + 1;
    localparam int PW    = MA + 20;
    localparam int SW    = COORD_BITS + 19;
    localparam int RW    = COORD_BITS + 5;
    localparam int ZW    = ((RW > 20) ? RW : 20) + 1;
    localparam int CRD_W = 40;
    localparam int RAM_W = DIST_W + 1;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_ROT     = 11'b00000000100,
        S_CHECK   = 11'b00000001000,
        S_SQUARE  = 11'b00000010000,
        S_CORDIC  = 11'b00000100000,
        S_BIN     = 11'b00001000000,
        S_UPD_RD  = 11'b00010000000,
        S_UPD_WR  = 11'b00100000000,
        S_READ    = 11'b01000000000,
        S_READ_OUT = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] k_reg, k_next;
    logic [AW-1:0] clr_reg, clr_next;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [19:0] hoff_reg, min_h_reg, max_h_reg;
    logic [RANGE_W-1:0] max_range_reg;
    logic [10:0] bin_count_reg;

    // Item and work registers.
    logic signed [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic [9:0] idx_reg;
    logic signed [SW-1:0] acc_reg, acc_next;
    logic signed [RW-1:0] xr_reg, yr_reg, zr_reg, xr_next, yr_next, zr_next;
    logic signed [19:0] xq_reg, yq_reg, xq_next, yq_next;
    logic [39:0] r2_reg, r2_next;
    logic signed [CRD_W-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic [31:0] ang_reg, ang_next;
    logic [39:0] sq_v_reg, sq_r_reg, sq_b_reg, sq_v_next, sq_r_next, sq_b_next;
    logic [CNT_W-1:0] bin_reg, bin_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [MA-1:0] mul_a;
    logic signed [19:0] mul_b;

    logic m_valid_reg, m_valid_next;
    logic [RANGE_W-1:0] m_range_reg, m_range_next;
    logic m_index_valid_reg, m_index_valid_next;

    // RAM port signals; each entry is {written, range}.
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RAM_W-1:0] ram_wdata, ram_rdata;

    logic [CNT_W-1:0] cnt;
    logic signed [SW-1:0] sum_full, sum_rnd;
    logic signed [ZW-1:0] zb, xe, ye, mr_s;
    logic drop;
    logic signed [CRD_W-1:0] cxs, cys;
    logic [31:0] ang_rnd;
    logic [ANGLE_BITS-1:0] angle;
    logic [CNT_W-1:0] bin_raw;
    logic [39:0] sq_t;
    logic s_fire;

    assign s_ready       = (state_reg == S_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_range_mm    = m_range_reg;
    assign m_index_valid = m_index_valid_reg;

    // Effective bin count: zero acts as one, above MAX_BINS acts as MAX_BINS.
    always_comb begin
        if (bin_count_reg == 11'd0) begin
            cnt = CNT_W'(1);
        end else if (CNT_W'(bin_count_reg) > CNT_W'(MAX_BINS)) begin
            cnt = CNT_W'(MAX_BINS);
        end else begin
            cnt = CNT_W'(bin_count_reg);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ROT: begin
                case (k_reg)
                    5'd0: begin mul_a = MA'(x_reg); mul_b = 20'(signed'(rot_x_reg[47:32])); end
                    5'd1: begin mul_a = MA'(y_reg); mul_b = 20'(signed'(rot_x_reg[31:16])); end
                    5'd2: begin mul_a = MA'(z_reg); mul_b = 20'(signed'(rot_x_reg[15:0])); end
                    5'd3: begin mul_a = MA'(x_reg); mul_b = 20'(signed'(rot_y_reg[47:32])); end
                    5'd4: begin mul_a = MA'(y_reg); mul_b = 20'(signed'(rot_y_reg[31:16])); end
                    5'd5: begin mul_a = MA'(z_reg); mul_b = 20'(signed'(rot_y_reg[15:0])); end
                    5'd6: begin mul_a = MA'(x_reg); mul_b = 20'(signed'(rot_z_reg[47:32])); end
                    5'd7: begin mul_a = MA'(y_reg); mul_b = 20'(signed'(rot_z_reg[31:16])); end
                    5'd8: begin mul_a = MA'(z_reg); mul_b = 20'(signed'(rot_z_reg[15:0])); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_SQUARE: begin
                case (k_reg)
                    5'd0: begin mul_a = MA'(xq_reg); mul_b = xq_reg; end
                    5'd1: begin mul_a = MA'(yq_reg); mul_b = yq_reg; end
                    default: begin
                        mul_a = MA'($signed({1'b0, max_range_reg}));
                        mul_b = $signed({1'b0, max_range_reg});
                    end
                endcase
            end
            S_BIN: begin
                mul_a = MA'($signed({1'b0, angle}));
                mul_b = 20'($signed({1'b0, cnt}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rotation accumulate and round half up to whole millimetres.
    assign sum_full = acc_reg + SW'(prod_reg);
    assign sum_rnd  = (sum_full + SW'(8192)) >>> 14;

    // Height window and range filters.
    assign zb   = ZW'(zr_reg) + ZW'(hoff_reg);
    assign xe   = ZW'(xr_reg);
    assign ye   = ZW'(yr_reg);
    assign mr_s = ZW'($signed({1'b0, max_range_reg}));
    assign drop = (zb < ZW'(min_h_reg)) || (zb > ZW'(max_h_reg))
               || ((xr_reg == '0) && (yr_reg == '0))
               || (xe >= mr_s) || (-xe >= mr_s) || (ye >= mr_s) || (-ye >= mr_s);

    // CORDIC shifter and bearing rounding.
    assign cxs     = cx_reg >>> k_reg;
    assign cys     = cy_reg >>> k_reg;
    assign ang_rnd = ang_reg + (32'd1 << (31 - ANGLE_BITS));
    assign angle   = ang_rnd[31 -: ANGLE_BITS];
    assign bin_raw = prod_reg[ANGLE_BITS +: CNT_W];
    assign sq_t    = sq_r_reg + sq_b_reg;

    always_comb begin
        state_next = state_reg;
        k_next = k_reg;
        clr_next = clr_reg;
        acc_next = acc_reg;
        xr_next = xr_reg;
        yr_next = yr_reg;
        zr_next = zr_reg;
        xq_next = xq_reg;
        yq_next = yq_reg;
        r2_next = r2_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        ang_next = ang_reg;
        sq_v_next = sq_v_reg;
        sq_r_next = sq_r_reg;
        sq_b_next = sq_b_reg;
        bin_next = bin_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_range_next = m_range_reg;
        m_index_valid_next = m_index_valid_reg;
        ram_we = 1'b0;
        ram_waddr = AW'(bin_reg);
        ram_wdata = {1'b1, sq_r_reg[DIST_W-1:0]};
        ram_raddr = AW'(bin_reg);

        case (state_reg)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_BINS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                k_next = '0;
                clr_next = '0;
                if (s_fire) begin
                    case (s_kind)
                        KIND_POINT: begin
                            if (s_finite && !((s_x_mm == '0) && (s_y_mm == '0)
                                    && (s_z_mm == '0))) begin
                                state_next = S_ROT;
                            end
                        end
                        KIND_READ: state_next = S_READ;
                        KIND_CLEAR: state_next = S_CLEAR;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ROT: begin
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd1 || k_reg == 5'd4 || k_reg == 5'd7) begin
                    acc_next = SW'(prod_reg);
                end else begin
                    acc_next = sum_full;
                end
                case (k_reg)
                    5'd3: xr_next = RW'(sum_rnd);
                    5'd6: yr_next = RW'(sum_rnd);
                    5'd9: begin
                        zr_next = RW'(sum_rnd);
                        state_next = S_CHECK;
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                k_next = '0;
                xq_next = 20'(xr_reg);
                yq_next = 20'(yr_reg);
                state_next = drop ? S_IDLE : S_SQUARE;
            end
            S_SQUARE: begin
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd1) begin
                    r2_next = 40'($unsigned(prod_reg));
                end else if (k_reg == 5'd2) begin
                    r2_next = r2_reg + 40'($unsigned(prod_reg));
                end else if (k_reg == 5'd3) begin
                    k_next = '0;
                    if (r2_reg >= 40'($unsigned(prod_reg))) begin
                        state_next = S_IDLE;
                    end else begin
                        // Pre-rotate by a half turn when x is negative.
                        if (xq_reg < 0) begin
                            cx_next = CRD_W'(-xq_reg) <<< 16;
                            cy_next = CRD_W'(-yq_reg) <<< 16;
                            ang_next = 32'h80000000;
                        end else begin
                            cx_next = CRD_W'(xq_reg) <<< 16;
                            cy_next = CRD_W'(yq_reg) <<< 16;
                            ang_next = '0;
                        end
                        sq_v_next = r2_reg;
                        sq_r_next = '0;
                        sq_b_next = 40'd1 << 38;
                        state_next = S_CORDIC;
                    end
                end
            end
            S_CORDIC: begin
                k_next = k_reg + 5'd1;
                if (cy_reg > 0) begin
                    cx_next = cx_reg + cys;
                    cy_next = cy_reg - cxs;
                    ang_next = ang_reg + atan_turn(k_reg);
                end else begin
                    cx_next = cx_reg - cys;
                    cy_next = cy_reg + cxs;
                    ang_next = ang_reg - atan_turn(k_reg);
                end
                // Integer square root, one result bit per step.
                if (k_reg < 5'(SQRT_STEPS)) begin
                    if (sq_v_reg >= sq_t) begin
                        sq_v_next = sq_v_reg - sq_t;
                        sq_r_next = (sq_r_reg >> 1) + sq_b_reg;
                    end else begin
                        sq_r_next = sq_r_reg >> 1;
                    end
                    sq_b_next = sq_b_reg >> 2;
                end
                if (k_reg == 5'(CORDIC_STEPS - 1)) begin
                    k_next = '0;
                    state_next = S_BIN;
                end
            end
            S_BIN: begin
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd1) begin
                    bin_next = (bin_raw > cnt - CNT_W'(1)) ? cnt - CNT_W'(1) : bin_raw;
                    state_next = S_UPD_RD;
                end
            end
            S_UPD_RD: begin
                state_next = S_UPD_WR;
            end
            S_UPD_WR: begin
                if (!ram_rdata[DIST_W] || (sq_r_reg[DIST_W-1:0] < ram_rdata[DIST_W-1:0])) begin
                    ram_we = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_READ: begin
                ram_raddr = AW'(idx_reg);
                state_next = S_READ_OUT;
            end
            S_READ_OUT: begin
                ram_raddr = AW'(idx_reg);
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_index_valid_next = (CNT_W'(idx_reg) < cnt);
                    if ((CNT_W'(idx_reg) < cnt) && ram_rdata[DIST_W]) begin
                        m_range_next = ram_rdata[RANGE_W-1:0];
                    end else begin
                        m_range_next = max_range_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            k_reg <= '0;
            clr_reg <= '0;
            m_valid_reg <= 1'b0;
            rot_x_reg <= 48'd70368744177664;
            rot_y_reg <= 48'd1073741824;
            rot_z_reg <= 48'd16384;
            hoff_reg <= 20'sd0;
            min_h_reg <= 20'sh80000;
            max_h_reg <= 20'sd524287;
            max_range_reg <= 19'd30000;
            bin_count_reg <= 11'd360;
        end else begin
            state_reg <= state_next;
            k_reg <= k_next;
            clr_reg <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROT_X:      rot_x_reg <= cfg_data;
                    CFG_ROT_Y:      rot_y_reg <= cfg_data;
                    CFG_ROT_Z:      rot_z_reg <= cfg_data;
                    CFG_HEIGHT_OFS: hoff_reg <= signed'(cfg_data[19:0]);
                    CFG_MIN_HEIGHT: min_h_reg <= signed'(cfg_data[19:0]);
                    CFG_MAX_HEIGHT: max_h_reg <= signed'(cfg_data[19:0]);
                    CFG_MAX_RANGE:  max_range_reg <= cfg_data[RANGE_W-1:0];
                    CFG_BIN_COUNT:  bin_count_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_reg <= s_x_mm;
            y_reg <= s_y_mm;
            z_reg <= s_z_mm;
            idx_reg <= s_bin_index;
        end
        prod_reg <= mul_a * mul_b;
        acc_reg <= acc_next;
        xr_reg <= xr_next;
        yr_reg <= yr_next;
        zr_reg <= zr_next;
        xq_reg <= xq_next;
        yq_reg <= yq_next;
        r2_reg <= r2_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        ang_reg <= ang_next;
        sq_v_reg <= sq_v_next;
        sq_r_reg <= sq_r_next;
        sq_b_reg <= sq_b_next;
        bin_reg <= bin_next;
        m_range_reg <= m_range_next;
        m_index_valid_reg <= m_index_valid_next;
    end

    pcrb_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_BINS)
    ) u_bins (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // A result only appears after the read output step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_READ_OUT))
        else $error("result appeared outside a read");

    // An out-of-range read reports the current maximum range.
    a_invalid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_index_valid) |-> (m_range_mm == max_range_reg))
        else $error("invalid index without max range");

    // A merged distance is always below the maximum range.
    a_dist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD_WR) |-> (sq_r_reg < 40'(max_range_reg)))
        else $error("merged distance not below max range");

endmodule

/* rtl/pcrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Uses pcrb_pkg for the DEF_MAX_BINS default depth.
module pcrb_ram
    import pcrb_pkg::*;
#(
    parameter int WIDTH = 21,
    parameter int DEPTH = DEF_MAX_BINS,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
